// File: rtl/mr3k_pkg.sv
// Shared constants, codes and lane-mask helpers for the R3000 integer core step block.
package mr3k_pkg;

    // result kinds
    localparam logic [2:0] K_RETIRED = 3'd0;
    localparam logic [2:0] K_READ    = 3'd1;
    localparam logic [2:0] K_WRITE   = 3'd2;
    localparam logic [2:0] K_HALTED  = 3'd3;
    localparam logic [2:0] K_FAULT   = 3'd4;
    localparam logic [2:0] K_UNSUPP  = 3'd5;
    localparam logic [2:0] K_BUDGET  = 3'd6;

    // wait phases (stopped phases reuse the kind codes)
    localparam logic [2:0] PH_INSTR  = 3'd0;
    localparam logic [2:0] PH_LOAD   = 3'd1;
    localparam logic [2:0] PH_MERGE  = 3'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_ENTRY_PC    = 2'd0;
    localparam logic [1:0] CFG_HALT_PC     = 2'd1;
    localparam logic [1:0] CFG_STEP_BUDGET = 2'd2;

    // multiply/divide operations: bit 1 divide, bit 0 unsigned
    typedef logic [1:0] md_op_t;
    localparam md_op_t MD_MULT  = 2'd0;
    localparam md_op_t MD_MULTU = 2'd1;
    localparam md_op_t MD_DIV   = 2'd2;
    localparam md_op_t MD_DIVU  = 2'd3;

    // primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0a;
    localparam logic [5:0] OP_SLTIU   = 6'h0b;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_ORI     = 6'h0d;
    localparam logic [5:0] OP_XORI    = 6'h0e;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_COP0    = 6'h10;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LWL     = 6'h22;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_LWR     = 6'h26;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SWL     = 6'h2a;
    localparam logic [5:0] OP_SW      = 6'h2b;
    localparam logic [5:0] OP_SWR     = 6'h2e;

    // SPECIAL function codes
    localparam logic [5:0] F_SLL   = 6'h00;
    localparam logic [5:0] F_SRL   = 6'h02;
    localparam logic [5:0] F_SRA   = 6'h03;
    localparam logic [5:0] F_SLLV  = 6'h04;
    localparam logic [5:0] F_SRLV  = 6'h06;
    localparam logic [5:0] F_SRAV  = 6'h07;
    localparam logic [5:0] F_JR    = 6'h08;
    localparam logic [5:0] F_JALR  = 6'h09;
    localparam logic [5:0] F_MFHI  = 6'h10;
    localparam logic [5:0] F_MTHI  = 6'h11;
    localparam logic [5:0] F_MFLO  = 6'h12;
    localparam logic [5:0] F_MTLO  = 6'h13;
    localparam logic [5:0] F_MULT  = 6'h18;
    localparam logic [5:0] F_MULTU = 6'h19;
    localparam logic [5:0] F_DIV   = 6'h1a;
    localparam logic [5:0] F_DIVU  = 6'h1b;
    localparam logic [5:0] F_ADD   = 6'h20;
    localparam logic [5:0] F_ADDU  = 6'h21;
    localparam logic [5:0] F_SUB   = 6'h22;
    localparam logic [5:0] F_SUBU  = 6'h23;
    localparam logic [5:0] F_AND   = 6'h24;
    localparam logic [5:0] F_OR    = 6'h25;
    localparam logic [5:0] F_XOR   = 6'h26;
    localparam logic [5:0] F_NOR   = 6'h27;
    localparam logic [5:0] F_SLT   = 6'h2a;
    localparam logic [5:0] F_SLTU  = 6'h2b;
    localparam logic [5:0] F_RFE   = 6'h10;

    // REGIMM rt codes
    localparam logic [4:0] RI_BLTZ   = 5'h00;
    localparam logic [4:0] RI_BGEZ   = 5'h01;
    localparam logic [4:0] RI_BLTZAL = 5'h10;
    localparam logic [4:0] RI_BGEZAL = 5'h11;

    // COP0 rs codes
    localparam logic [4:0] C0_MF = 5'h00;
    localparam logic [4:0] C0_MT = 5'h04;
    localparam logic [4:0] C0_CO = 5'h10;

    localparam logic [4:0] LINK_REG   = 5'd31;
    localparam logic [4:0] STATUS_IDX = 5'd12;

    function automatic logic [31:0] lwl_keep(input logic [1:0] k);
        logic [31:0] m;
        case (k)
            2'd0:    m = 32'h00ffffff;
            2'd1:    m = 32'h0000ffff;
            2'd2:    m = 32'h000000ff;
            default: m = 32'h00000000;
        endcase
        return m;
    endfunction

    function automatic logic [31:0] lwr_keep(input logic [1:0] k);
        logic [31:0] m;
        case (k)
            2'd0:    m = 32'h00000000;
            2'd1:    m = 32'hff000000;
            2'd2:    m = 32'hffff0000;
            default: m = 32'hffffff00;
        endcase
        return m;
    endfunction

    function automatic logic [31:0] swl_keep(input logic [1:0] k);
        logic [31:0] m;
        case (k)
            2'd0:    m = 32'hffffff00;
            2'd1:    m = 32'hffff0000;
            2'd2:    m = 32'hff000000;
            default: m = 32'h00000000;
        endcase
        return m;
    endfunction

    function automatic logic [31:0] swr_keep(input logic [1:0] k);
        logic [31:0] m;
        case (k)
            2'd0:    m = 32'h00000000;
            2'd1:    m = 32'h000000ff;
            2'd2:    m = 32'h0000ffff;
            default: m = 32'h00ffffff;
        endcase
        return m;
    endfunction

    // (3 - k) * 8 and k * 8
    function automatic logic [4:0] left_sh(input logic [1:0] k);
        return {~k, 3'b000};
    endfunction

    function automatic logic [4:0] right_sh(input logic [1:0] k);
        return {k, 3'b000};
    endfunction

endpackage

// File: rtl/mr3k_item_if.sv
// Input channel: instruction words and memory read responses.
interface mr3k_item_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] instr_word;
    logic [31:0] read_data;
    logic        bus_error;

    modport source (output valid, output cmd, output instr_word, output read_data,
                    output bus_error, input ready);
    modport sink   (input valid, input cmd, input instr_word, input read_data,
                    input bus_error, output ready);
endinterface

// File: rtl/mr3k_result_if.sv
// Output channel: retire, memory request and stop words.
interface mr3k_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] mem_address;
    logic [31:0] mem_data;
    logic [2:0]  mem_bytes;
    logic [31:0] fetch_pc;

    modport source (output valid, output kind, output mem_address, output mem_data,
                    output mem_bytes, output fetch_pc, input ready);
    modport sink   (input valid, input kind, input mem_address, input mem_data,
                    input mem_bytes, input fetch_pc, output ready);
endinterface

// File: rtl/mr3k_muldiv.sv
// Iterative multiply/divide unit: one shift-add or restoring step per cycle.
module mr3k_muldiv (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  mr3k_pkg::md_op_t     op,
    input  logic [31:0]          a,
    input  logic [31:0]          b,
    output logic                 done,
    output logic [31:0]          hi,
    output logic [31:0]          lo
);

    localparam logic [1:0] MS_IDLE = 2'd0;
    localparam logic [1:0] MS_RUN  = 2'd1;
    localparam logic [1:0] MS_FIX  = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] acc_hi_reg, acc_hi_next;
    logic [31:0] acc_lo_reg, acc_lo_next;
    logic [31:0] opnd_reg, opnd_next;
    logic [31:0] dvd_reg, dvd_next;
    logic        div_reg, div_next;
    logic        neg_q_reg, neg_q_next;
    logic        neg_r_reg, neg_r_next;
    logic        zero_reg, zero_next;
    logic [31:0] hi_reg, hi_next;
    logic [31:0] lo_reg, lo_next;
    logic        done_reg, done_next;

    always_comb
    begin
        logic        sgn;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [32:0] msum;
        logic [32:0] shin;
        logic [33:0] dsub;
        logic [63:0] prod;
        logic [63:0] negp;

        sgn  = !op[0];
        ma   = (sgn && a[31]) ? (32'd0 - a) : a;
        mb   = (sgn && b[31]) ? (32'd0 - b) : b;
        msum = {1'b0, acc_hi_reg} + {1'b0, (acc_lo_reg[0] ? opnd_reg : 32'd0)};
        shin = {acc_hi_reg, acc_lo_reg[31]};
        dsub = {1'b0, shin} - {2'b00, opnd_reg};
        prod = {acc_hi_reg, acc_lo_reg};
        negp = 64'd0 - prod;

        state_next  = state_reg;
        cnt_next    = cnt_reg;
        acc_hi_next = acc_hi_reg;
        acc_lo_next = acc_lo_reg;
        opnd_next   = opnd_reg;
        dvd_next    = dvd_reg;
        div_next    = div_reg;
        neg_q_next  = neg_q_reg;
        neg_r_next  = neg_r_reg;
        zero_next   = zero_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        done_next   = 1'b0;

        unique case (state_reg)
            MS_IDLE:
            begin
                if (start)
                begin
                    div_next    = op[1];
                    neg_q_next  = sgn && (a[31] ^ b[31]);
                    neg_r_next  = sgn && a[31];
                    zero_next   = (b == 32'd0);
                    dvd_next    = a;
                    acc_hi_next = 32'd0;
                    acc_lo_next = op[1] ? ma : mb;
                    opnd_next   = op[1] ? mb : ma;
                    cnt_next    = 5'd0;
                    state_next  = (op[1] && (b == 32'd0)) ? MS_FIX : MS_RUN;
                end
            end
            MS_RUN:
            begin
                if (div_reg)
                begin
                    if (!dsub[33])
                    begin
                        acc_hi_next = dsub[31:0];
                        acc_lo_next = {acc_lo_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        acc_hi_next = shin[31:0];
                        acc_lo_next = {acc_lo_reg[30:0], 1'b0};
                    end
                end
                else
                begin
                    acc_hi_next = msum[32:1];
                    acc_lo_next = {msum[0], acc_lo_reg[31:1]};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                    state_next = MS_FIX;
            end
            MS_FIX:
            begin
                if (!div_reg)
                begin
                    {hi_next, lo_next} = neg_q_reg ? negp : prod;
                end
                else if (zero_reg)
                begin
                    lo_next = neg_r_reg ? 32'd1 : 32'hffffffff;
                    hi_next = dvd_reg;
                end
                else
                begin
                    lo_next = neg_q_reg ? (32'd0 - acc_lo_reg) : acc_lo_reg;
                    hi_next = neg_r_reg ? (32'd0 - acc_hi_reg) : acc_hi_reg;
                end
                done_next  = 1'b1;
                state_next = MS_IDLE;
            end
            default:
            begin
                state_next = MS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        acc_hi_reg <= acc_hi_next;
        acc_lo_reg <= acc_lo_next;
        opnd_reg   <= opnd_next;
        dvd_reg    <= dvd_next;
        div_reg    <= div_next;
        neg_q_reg  <= neg_q_next;
        neg_r_reg  <= neg_r_next;
        zero_reg   <= zero_next;
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
    end

    assign done = done_reg;
    assign hi   = hi_reg;
    assign lo   = lo_reg;

endmodule

// File: rtl/mips_r3000_integer_core_step.sv
// Top level: multicycle R3000 integer core stepped one word at a time.
//
//   channel  dir  handshake      payload
//   item     in   valid/ready    cmd, instr_word, read_data, bus_error
//   result   out  valid/ready    kind, mem_address, mem_data, mem_bytes, fetch_pc
//   cfg      in   cfg_we only    cfg_index, cfg_data
//
// Instruction word: accept, register read, execute, pending-load read and merge,
// result load; MULT/DIV wait in the iterative multiply/divide unit after execute,
// loads and stops skip to result load. Response word: accept, response, pending-load
// read and merge, result load. Stop words: accept, result load. item.ready is high
// only while the sequencer is idle; a full result register stalls the sequencer in
// its last step. Reset clears the register files through valid bits, no clearing pass.
module mips_r3000_integer_core_step (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [63:0]          cfg_data,
    mr3k_item_if.sink            item,
    mr3k_result_if.source        result
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_MDWAIT = 3'd3;
    localparam logic [2:0] S_RET_RD = 3'd4;
    localparam logic [2:0] S_RET_WR = 3'd5;
    localparam logic [2:0] S_RESP   = 3'd6;
    localparam logic [2:0] S_EMIT   = 3'd7;

    // architectural and control state
    logic [2:0]  state_reg, state_next;
    logic [2:0]  phase_reg, phase_next;
    logic [31:0] cur_pc_reg, cur_pc_next;
    logic [31:0] fol_pc_reg, fol_pc_next;
    logic [31:0] halt_pc_reg, halt_pc_next;
    logic [63:0] budget_reg, budget_next;
    logic [63:0] step_cnt_reg, step_cnt_next;
    logic [31:0] hi_reg, hi_next;
    logic [31:0] lo_reg, lo_next;
    logic        dl_valid_reg, dl_valid_next;
    logic [4:0]  dl_target_reg, dl_target_next;
    logic [31:0] dl_value_reg, dl_value_next;
    logic [31:0] dl_keep_reg, dl_keep_next;
    logic        out_valid_reg, out_valid_next;

    // working registers
    logic [31:0] instr_reg, instr_next;
    logic [31:0] addr_reg, addr_next;
    logic [31:0] b_reg, b_next;
    logic [31:0] data_reg, data_next;
    logic        np_valid_reg, np_valid_next;
    logic [4:0]  np_target_reg, np_target_next;
    logic [31:0] np_value_reg, np_value_next;
    logic [31:0] np_keep_reg, np_keep_next;
    logic [4:0]  wr_idx_reg, wr_idx_next;
    logic [31:0] newfol_reg, newfol_next;
    logic [2:0]  res_kind_reg, res_kind_next;
    logic [31:0] res_addr_reg, res_addr_next;
    logic [31:0] res_data_reg, res_data_next;
    logic [2:0]  res_bytes_reg, res_bytes_next;
    logic [31:0] res_pc_reg, res_pc_next;
    logic [2:0]  out_kind_reg, out_kind_next;
    logic [31:0] out_addr_reg, out_addr_next;
    logic [31:0] out_data_reg, out_data_next;
    logic [2:0]  out_bytes_reg, out_bytes_next;
    logic [31:0] out_pc_reg, out_pc_next;

    // register files
    logic [31:0] gen_mem [32];
    logic [31:0] ctrl_mem [32];
    logic [31:0] gen_valid_reg;
    logic [31:0] ctrl_valid_reg;
    logic [31:0] ga_rdata_reg;
    logic [31:0] gb_rdata_reg;
    logic [31:0] c_rdata_reg;
    logic [4:0]  ra;
    logic [4:0]  rb;
    logic [4:0]  ca;
    logic        gwe;
    logic [4:0]  gwa;
    logic [31:0] gwd;
    logic        cwe;
    logic [4:0]  cwa;
    logic [31:0] cwd;

    logic        md_start;
    logic        md_done;
    logic [31:0] md_hi;
    logic [31:0] md_lo;

    mr3k_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (md_start),
        .op    (instr_reg[1:0]),
        .a     (ga_rdata_reg),
        .b     (gb_rdata_reg),
        .done  (md_done),
        .hi    (md_hi),
        .lo    (md_lo)
    );

    assign item.ready = (state_reg == S_IDLE);

    always_comb
    begin
        logic [5:0]  op;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  sa;
        logic [5:0]  fn;
        logic [31:0] uimm;
        logic [31:0] simm;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] sum;
        logic [31:0] diff;
        logic [31:0] addr;
        logic [31:0] btarget;
        logic [31:0] res;
        logic [31:0] nf;
        logic [4:0]  wi;
        logic        wr;
        logic [2:0]  stopk;
        logic        take;
        logic        ld;
        logic        st;
        logic        md_go;
        logic        wordal;
        logic        merge;
        logic [1:0]  amask;
        logic [2:0]  bytes;
        logic [31:0] sdata;
        logic [1:0]  k;
        logic [31:0] d;
        logic [5:0]  hop;

        op      = instr_reg[31:26];
        rs      = instr_reg[25:21];
        rt      = instr_reg[20:16];
        rd      = instr_reg[15:11];
        sa      = instr_reg[10:6];
        fn      = instr_reg[5:0];
        uimm    = {16'd0, instr_reg[15:0]};
        simm    = {{16{instr_reg[15]}}, instr_reg[15:0]};
        a       = ga_rdata_reg;
        b       = gb_rdata_reg;
        sum     = a + b;
        diff    = a - b;
        addr    = a + simm;
        btarget = cur_pc_reg + 32'd4 + {simm[29:0], 2'b00};
        res     = 32'd0;
        nf      = fol_pc_reg + 32'd4;
        wi      = rd;
        wr      = 1'b0;
        stopk   = mr3k_pkg::K_RETIRED;
        take    = 1'b0;
        ld      = 1'b0;
        st      = 1'b0;
        md_go   = 1'b0;
        wordal  = 1'b0;
        merge   = 1'b0;
        amask   = 2'b00;
        bytes   = 3'd4;
        sdata   = b;
        k       = addr_reg[1:0];
        d       = data_reg;
        hop     = instr_reg[31:26];

        state_next     = state_reg;
        phase_next     = phase_reg;
        cur_pc_next    = cur_pc_reg;
        fol_pc_next    = fol_pc_reg;
        halt_pc_next   = halt_pc_reg;
        budget_next    = budget_reg;
        step_cnt_next  = step_cnt_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        dl_valid_next  = dl_valid_reg;
        dl_target_next = dl_target_reg;
        dl_value_next  = dl_value_reg;
        dl_keep_next   = dl_keep_reg;
        out_valid_next = out_valid_reg;
        instr_next     = instr_reg;
        addr_next      = addr_reg;
        b_next         = b_reg;
        data_next      = data_reg;
        np_valid_next  = np_valid_reg;
        np_target_next = np_target_reg;
        np_value_next  = np_value_reg;
        np_keep_next   = np_keep_reg;
        wr_idx_next    = wr_idx_reg;
        newfol_next    = newfol_reg;
        res_kind_next  = res_kind_reg;
        res_addr_next  = res_addr_reg;
        res_data_next  = res_data_reg;
        res_bytes_next = res_bytes_reg;
        res_pc_next    = res_pc_reg;
        out_kind_next  = out_kind_reg;
        out_addr_next  = out_addr_reg;
        out_data_next  = out_data_reg;
        out_bytes_next = out_bytes_reg;
        out_pc_next    = out_pc_reg;
        ra             = rs;
        rb             = rt;
        ca             = rd;
        gwe            = 1'b0;
        gwa            = rd;
        gwd            = 32'd0;
        cwe            = 1'b0;
        cwa            = rd;
        cwd            = b;
        md_start       = 1'b0;

        if (out_valid_reg && result.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                res_addr_next  = 32'd0;
                res_data_next  = 32'd0;
                res_bytes_next = 3'd0;
                res_pc_next    = cur_pc_reg;
                if (item.valid)
                begin
                    if (phase_reg >= mr3k_pkg::K_HALTED)
                    begin
                        res_kind_next = phase_reg;
                        state_next    = S_EMIT;
                    end
                    else if (phase_reg == mr3k_pkg::PH_INSTR)
                    begin
                        if (!item.cmd)
                        begin
                            if (step_cnt_reg >= budget_reg)
                                stopk = mr3k_pkg::K_BUDGET;
                            else if (cur_pc_reg == halt_pc_reg)
                                stopk = mr3k_pkg::K_HALTED;
                            else if (item.bus_error)
                                stopk = mr3k_pkg::K_FAULT;
                            if (stopk != mr3k_pkg::K_RETIRED)
                            begin
                                phase_next    = stopk;
                                res_kind_next = stopk;
                                state_next    = S_EMIT;
                            end
                            else
                            begin
                                step_cnt_next = step_cnt_reg + 64'd1;
                                instr_next    = item.instr_word;
                                state_next    = S_READ;
                            end
                        end
                    end
                    else if (item.cmd)
                    begin
                        if (item.bus_error)
                        begin
                            phase_next    = mr3k_pkg::K_FAULT;
                            res_kind_next = mr3k_pkg::K_FAULT;
                            state_next    = S_EMIT;
                        end
                        else
                        begin
                            data_next  = item.read_data;
                            state_next = S_RESP;
                        end
                    end
                end
            end

            S_READ:
            begin
                ra = rs;
                rb = rt;
                ca = (op == mr3k_pkg::OP_COP0 && rs == mr3k_pkg::C0_CO) ?
                     mr3k_pkg::STATUS_IDX : rd;
                state_next = S_EXEC;
            end

            S_EXEC:
            begin
                np_valid_next  = 1'b0;
                np_target_next = 5'd0;
                np_value_next  = 32'd0;
                np_keep_next   = 32'd0;
                unique case (op) inside
                    mr3k_pkg::OP_SPECIAL:
                    begin
                        unique case (fn)
                            mr3k_pkg::F_SLL:   begin wr = 1'b1; res = b << sa; end
                            mr3k_pkg::F_SRL:   begin wr = 1'b1; res = b >> sa; end
                            mr3k_pkg::F_SRA:
                            begin
                                wr  = 1'b1;
                                res = $unsigned($signed(b) >>> sa);
                            end
                            mr3k_pkg::F_SLLV:  begin wr = 1'b1; res = b << a[4:0]; end
                            mr3k_pkg::F_SRLV:  begin wr = 1'b1; res = b >> a[4:0]; end
                            mr3k_pkg::F_SRAV:
                            begin
                                wr  = 1'b1;
                                res = $unsigned($signed(b) >>> a[4:0]);
                            end
                            mr3k_pkg::F_JR:    nf = a;
                            mr3k_pkg::F_JALR:
                            begin
                                nf  = a;
                                wr  = 1'b1;
                                res = cur_pc_reg + 32'd8;
                            end
                            mr3k_pkg::F_MFHI:  begin wr = 1'b1; res = hi_reg; end
                            mr3k_pkg::F_MTHI:  hi_next = a;
                            mr3k_pkg::F_MFLO:  begin wr = 1'b1; res = lo_reg; end
                            mr3k_pkg::F_MTLO:  lo_next = a;
                            mr3k_pkg::F_MULT, mr3k_pkg::F_MULTU,
                            mr3k_pkg::F_DIV, mr3k_pkg::F_DIVU:
                                md_go = 1'b1;
                            mr3k_pkg::F_ADD:
                            begin
                                if (((a ^ sum) & (b ^ sum)) >> 31 != 32'd0)
                                    stopk = mr3k_pkg::K_FAULT;
                                else
                                begin
                                    wr  = 1'b1;
                                    res = sum;
                                end
                            end
                            mr3k_pkg::F_ADDU:  begin wr = 1'b1; res = sum; end
                            mr3k_pkg::F_SUB:
                            begin
                                if (((a ^ b) & (a ^ diff)) >> 31 != 32'd0)
                                    stopk = mr3k_pkg::K_FAULT;
                                else
                                begin
                                    wr  = 1'b1;
                                    res = diff;
                                end
                            end
                            mr3k_pkg::F_SUBU:  begin wr = 1'b1; res = diff; end
                            mr3k_pkg::F_AND:   begin wr = 1'b1; res = a & b; end
                            mr3k_pkg::F_OR:    begin wr = 1'b1; res = a | b; end
                            mr3k_pkg::F_XOR:   begin wr = 1'b1; res = a ^ b; end
                            mr3k_pkg::F_NOR:   begin wr = 1'b1; res = ~(a | b); end
                            mr3k_pkg::F_SLT:
                            begin
                                wr  = 1'b1;
                                res = {31'd0, $signed(a) < $signed(b)};
                            end
                            mr3k_pkg::F_SLTU:
                            begin
                                wr  = 1'b1;
                                res = {31'd0, a < b};
                            end
                            default:           stopk = mr3k_pkg::K_UNSUPP;
                        endcase
                    end
                    mr3k_pkg::OP_REGIMM:
                    begin
                        if (rt == mr3k_pkg::RI_BLTZ || rt == mr3k_pkg::RI_BLTZAL)
                            take = a[31];
                        else if (rt == mr3k_pkg::RI_BGEZ || rt == mr3k_pkg::RI_BGEZAL)
                            take = !a[31];
                        else
                            stopk = mr3k_pkg::K_UNSUPP;
                        if (rt[4])
                        begin
                            wr  = 1'b1;
                            wi  = mr3k_pkg::LINK_REG;
                            res = cur_pc_reg + 32'd8;
                        end
                        if (take)
                            nf = btarget;
                    end
                    mr3k_pkg::OP_J, mr3k_pkg::OP_JAL:
                    begin
                        if (op == mr3k_pkg::OP_JAL)
                        begin
                            wr  = 1'b1;
                            wi  = mr3k_pkg::LINK_REG;
                            res = cur_pc_reg + 32'd8;
                        end
                        nf = {sum[31:28] & 4'h0 | btarget[31:28] & 4'h0 |
                              (cur_pc_reg[31:28] + {3'd0, &cur_pc_reg[27:2]}),
                              instr_reg[25:0], 2'b00};
                    end
                    mr3k_pkg::OP_BEQ:  if (a == b) nf = btarget;
                    mr3k_pkg::OP_BNE:  if (a != b) nf = btarget;
                    mr3k_pkg::OP_BLEZ: if (a[31] || a == 32'd0) nf = btarget;
                    mr3k_pkg::OP_BGTZ: if (!a[31] && a != 32'd0) nf = btarget;
                    mr3k_pkg::OP_ADDI:
                    begin
                        wi = rt;
                        if (((a ^ addr) & (simm ^ addr)) >> 31 != 32'd0)
                            stopk = mr3k_pkg::K_FAULT;
                        else
                        begin
                            wr  = 1'b1;
                            res = addr;
                        end
                    end
                    mr3k_pkg::OP_ADDIU: begin wi = rt; wr = 1'b1; res = addr; end
                    mr3k_pkg::OP_SLTI:
                    begin
                        wi  = rt;
                        wr  = 1'b1;
                        res = {31'd0, $signed(a) < $signed(simm)};
                    end
                    mr3k_pkg::OP_SLTIU:
                    begin
                        wi  = rt;
                        wr  = 1'b1;
                        res = {31'd0, a < simm};
                    end
                    mr3k_pkg::OP_ANDI: begin wi = rt; wr = 1'b1; res = a & uimm; end
                    mr3k_pkg::OP_ORI:  begin wi = rt; wr = 1'b1; res = a | uimm; end
                    mr3k_pkg::OP_XORI: begin wi = rt; wr = 1'b1; res = a ^ uimm; end
                    mr3k_pkg::OP_LUI:
                    begin
                        wi  = rt;
                        wr  = 1'b1;
                        res = {instr_reg[15:0], 16'd0};
                    end
                    mr3k_pkg::OP_COP0:
                    begin
                        if (rs == mr3k_pkg::C0_MF)
                        begin
                            if (rt != 5'd0)
                            begin
                                np_valid_next  = 1'b1;
                                np_target_next = rt;
                                np_value_next  = c_rdata_reg;
                            end
                        end
                        else if (rs == mr3k_pkg::C0_MT)
                        begin
                            cwe = 1'b1;
                            cwa = rd;
                            cwd = b;
                        end
                        else if (rs == mr3k_pkg::C0_CO && fn == mr3k_pkg::F_RFE)
                        begin
                            // pop the interrupt/mode stack: bits 3:0 take bits 5:2
                            cwe = 1'b1;
                            cwa = mr3k_pkg::STATUS_IDX;
                            cwd = {c_rdata_reg[31:4], c_rdata_reg[5:2]};
                        end
                        else
                            stopk = mr3k_pkg::K_UNSUPP;
                    end
                    mr3k_pkg::OP_LB, mr3k_pkg::OP_LBU:
                    begin
                        ld    = 1'b1;
                        bytes = 3'd1;
                    end
                    mr3k_pkg::OP_LH, mr3k_pkg::OP_LHU:
                    begin
                        ld    = 1'b1;
                        bytes = 3'd2;
                        amask = 2'b01;
                    end
                    mr3k_pkg::OP_LW:
                    begin
                        ld    = 1'b1;
                        amask = 2'b11;
                    end
                    mr3k_pkg::OP_LWL, mr3k_pkg::OP_LWR:
                    begin
                        ld     = 1'b1;
                        wordal = 1'b1;
                    end
                    mr3k_pkg::OP_SWL, mr3k_pkg::OP_SWR:
                    begin
                        ld     = 1'b1;
                        wordal = 1'b1;
                        merge  = 1'b1;
                    end
                    mr3k_pkg::OP_SB:
                    begin
                        st    = 1'b1;
                        bytes = 3'd1;
                        sdata = {24'd0, b[7:0]};
                    end
                    mr3k_pkg::OP_SH:
                    begin
                        st    = 1'b1;
                        bytes = 3'd2;
                        sdata = {16'd0, b[15:0]};
                        amask = 2'b01;
                    end
                    mr3k_pkg::OP_SW:
                    begin
                        st    = 1'b1;
                        amask = 2'b11;
                    end
                    default: stopk = mr3k_pkg::K_UNSUPP;
                endcase

                if ((ld || st) && (addr[1:0] & amask) != 2'b00)
                    stopk = mr3k_pkg::K_FAULT;

                res_addr_next  = 32'd0;
                res_data_next  = 32'd0;
                res_bytes_next = 3'd0;
                newfol_next    = nf;
                wr_idx_next    = 5'd0;

                if (stopk != mr3k_pkg::K_RETIRED)
                begin
                    // nothing architectural changes on a stop
                    hi_next        = hi_reg;
                    lo_next        = lo_reg;
                    cwe            = 1'b0;
                    np_valid_next  = 1'b0;
                    phase_next     = stopk;
                    res_kind_next  = stopk;
                    res_pc_next    = cur_pc_reg;
                    state_next     = S_EMIT;
                end
                else if (ld)
                begin
                    addr_next      = addr;
                    b_next         = b;
                    phase_next     = merge ? mr3k_pkg::PH_MERGE : mr3k_pkg::PH_LOAD;
                    res_kind_next  = mr3k_pkg::K_READ;
                    res_addr_next  = wordal ? {addr[31:2], 2'b00} : addr;
                    res_bytes_next = bytes;
                    res_pc_next    = cur_pc_reg;
                    state_next     = S_EMIT;
                end
                else if (st)
                begin
                    res_kind_next  = mr3k_pkg::K_WRITE;
                    res_addr_next  = addr;
                    res_data_next  = sdata;
                    res_bytes_next = bytes;
                    res_pc_next    = fol_pc_reg;
                    state_next     = S_RET_RD;
                end
                else
                begin
                    if (md_go)
                        md_start = 1'b1;
                    if (wr && wi != 5'd0)
                    begin
                        gwe         = 1'b1;
                        gwa         = wi;
                        gwd         = res;
                        wr_idx_next = wi;
                    end
                    res_kind_next = mr3k_pkg::K_RETIRED;
                    res_pc_next   = fol_pc_reg;
                    state_next    = md_go ? S_MDWAIT : S_RET_RD;
                end
            end

            S_MDWAIT:
            begin
                if (md_done)
                begin
                    hi_next    = md_hi;
                    lo_next    = md_lo;
                    state_next = S_RET_RD;
                end
            end

            S_RESP:
            begin
                np_valid_next  = 1'b0;
                np_target_next = 5'd0;
                np_value_next  = 32'd0;
                np_keep_next   = 32'd0;
                wr_idx_next    = 5'd0;
                newfol_next    = fol_pc_reg + 32'd4;
                res_addr_next  = 32'd0;
                res_data_next  = 32'd0;
                res_bytes_next = 3'd0;
                res_pc_next    = fol_pc_reg;
                if (phase_reg == mr3k_pkg::PH_MERGE)
                begin
                    res_kind_next  = mr3k_pkg::K_WRITE;
                    res_addr_next  = {addr_reg[31:2], 2'b00};
                    res_bytes_next = 3'd4;
                    if (hop == mr3k_pkg::OP_SWL)
                        res_data_next = (d & mr3k_pkg::swl_keep(k)) |
                                        (b_reg >> mr3k_pkg::left_sh(k));
                    else
                        res_data_next = (d & mr3k_pkg::swr_keep(k)) |
                                        (b_reg << mr3k_pkg::right_sh(k));
                end
                else
                begin
                    res_kind_next  = mr3k_pkg::K_RETIRED;
                    np_valid_next  = (rt != 5'd0);
                    np_target_next = rt;
                    case (hop)
                        mr3k_pkg::OP_LB:  np_value_next = {{24{d[7]}}, d[7:0]};
                        mr3k_pkg::OP_LBU: np_value_next = {24'd0, d[7:0]};
                        mr3k_pkg::OP_LH:  np_value_next = {{16{d[15]}}, d[15:0]};
                        mr3k_pkg::OP_LHU: np_value_next = {16'd0, d[15:0]};
                        mr3k_pkg::OP_LWL:
                        begin
                            np_value_next = d << mr3k_pkg::left_sh(k);
                            np_keep_next  = mr3k_pkg::lwl_keep(k);
                        end
                        mr3k_pkg::OP_LWR:
                        begin
                            np_value_next = d >> mr3k_pkg::right_sh(k);
                            np_keep_next  = mr3k_pkg::lwr_keep(k);
                        end
                        default:          np_value_next = d;
                    endcase
                end
                phase_next = mr3k_pkg::PH_INSTR;
                state_next = S_RET_RD;
            end

            S_RET_RD:
            begin
                ra         = dl_target_reg;
                state_next = S_RET_WR;
            end

            S_RET_WR:
            begin
                // merge the load from the previous slot unless this one wrote it
                if (dl_valid_reg && dl_target_reg != 5'd0 && dl_target_reg != wr_idx_reg)
                begin
                    gwe = 1'b1;
                    gwa = dl_target_reg;
                    gwd = (ga_rdata_reg & dl_keep_reg) | dl_value_reg;
                end
                dl_valid_next  = np_valid_reg;
                dl_target_next = np_target_reg;
                dl_value_next  = np_value_reg;
                dl_keep_next   = np_keep_reg;
                cur_pc_next    = fol_pc_reg;
                fol_pc_next    = newfol_reg;
                state_next     = S_EMIT;
            end

            S_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = res_kind_reg;
                    out_addr_next  = res_addr_reg;
                    out_data_next  = res_data_reg;
                    out_bytes_next = res_bytes_reg;
                    out_pc_next    = res_pc_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            case (cfg_index)
                mr3k_pkg::CFG_ENTRY_PC:
                begin
                    cur_pc_next = cfg_data[31:0];
                    fol_pc_next = cfg_data[31:0] + 32'd4;
                    phase_next  = mr3k_pkg::PH_INSTR;
                end
                mr3k_pkg::CFG_HALT_PC:    halt_pc_next = cfg_data[31:0];
                mr3k_pkg::CFG_STEP_BUDGET: budget_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= mr3k_pkg::PH_INSTR;
            cur_pc_reg     <= 32'd0;
            fol_pc_reg     <= 32'd4;
            halt_pc_reg    <= 32'd0;
            budget_reg     <= 64'd0;
            step_cnt_reg   <= 64'd0;
            hi_reg         <= 32'd0;
            lo_reg         <= 32'd0;
            dl_valid_reg   <= 1'b0;
            dl_target_reg  <= 5'd0;
            dl_value_reg   <= 32'd0;
            dl_keep_reg    <= 32'd0;
            out_valid_reg  <= 1'b0;
            gen_valid_reg  <= 32'd0;
            ctrl_valid_reg <= 32'd0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cur_pc_reg    <= cur_pc_next;
            fol_pc_reg    <= fol_pc_next;
            halt_pc_reg   <= halt_pc_next;
            budget_reg    <= budget_next;
            step_cnt_reg  <= step_cnt_next;
            hi_reg        <= hi_next;
            lo_reg        <= lo_next;
            dl_valid_reg  <= dl_valid_next;
            dl_target_reg <= dl_target_next;
            dl_value_reg  <= dl_value_next;
            dl_keep_reg   <= dl_keep_next;
            out_valid_reg <= out_valid_next;
            if (gwe)
                gen_valid_reg[gwa] <= 1'b1;
            if (cwe)
                ctrl_valid_reg[cwa] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        instr_reg     <= instr_next;
        addr_reg      <= addr_next;
        b_reg         <= b_next;
        data_reg      <= data_next;
        np_valid_reg  <= np_valid_next;
        np_target_reg <= np_target_next;
        np_value_reg  <= np_value_next;
        np_keep_reg   <= np_keep_next;
        wr_idx_reg    <= wr_idx_next;
        newfol_reg    <= newfol_next;
        res_kind_reg  <= res_kind_next;
        res_addr_reg  <= res_addr_next;
        res_data_reg  <= res_data_next;
        res_bytes_reg <= res_bytes_next;
        res_pc_reg    <= res_pc_next;
        out_kind_reg  <= out_kind_next;
        out_addr_reg  <= out_addr_next;
        out_data_reg  <= out_data_next;
        out_bytes_reg <= out_bytes_next;
        out_pc_reg    <= out_pc_next;
    end

    // register files: one write port each, registered reads, unwritten entries read zero
    always_ff @(posedge clk)
    begin
        if (gwe)
            gen_mem[gwa] <= gwd;
        if (cwe)
            ctrl_mem[cwa] <= cwd;
        ga_rdata_reg <= gen_valid_reg[ra] ? gen_mem[ra] : 32'd0;
        gb_rdata_reg <= gen_valid_reg[rb] ? gen_mem[rb] : 32'd0;
        c_rdata_reg  <= ctrl_valid_reg[ca] ? ctrl_mem[ca] : 32'd0;
    end

    assign result.valid       = out_valid_reg;
    assign result.kind        = out_kind_reg;
    assign result.mem_address = out_addr_reg;
    assign result.mem_data    = out_data_reg;
    assign result.mem_bytes   = out_bytes_reg;
    assign result.fetch_pc    = out_pc_reg;

`ifndef ASSERT_OFF
    a_md_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        md_done |-> state_reg == S_MDWAIT)
        else $error("muldiv finished outside its wait state");

    a_no_r0_write: assert property (@(posedge clk) disable iff (!rst_n)
        gwe |-> gwa != 5'd0)
        else $error("write to register zero");

    a_pend_target: assert property (@(posedge clk) disable iff (!rst_n)
        dl_valid_reg |-> dl_target_reg != 5'd0)
        else $error("pending load aimed at register zero");

    a_exec_phase: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |-> phase_reg == mr3k_pkg::PH_INSTR)
        else $error("execute step outside instruction phase");
`endif

endmodule
